### sv/urlpd_pkg.sv
package urlpd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] byte_count;
    logic       done_res;
    logic       stopped_early;
  } out_item_t;

  // classified input item, passed from front to back through the queue
  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_plain;
    logic       is_pct;
    logic       is_u;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       last;
  } cls_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PERCENT = 3'd1,
    PH_SECOND  = 3'd2,
    PH_UDIGITS = 3'd3,
    PH_HALTED  = 3'd4
  } phase_t;

  localparam logic [7:0] CHAR_PCT = 8'h25;
  localparam logic [7:0] CHAR_U   = 8'h75;
  localparam logic [1:0] LAST_U_DIGIT = 2'd3;

endpackage

### sv/urlpd_front.sv
module urlpd_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  urlpd_pkg::in_item_t in_item,
  input  logic                q_full,
  output logic                q_push,
  output urlpd_pkg::cls_t     q_data
);

  logic [7:0] b;
  logic       is_digit;
  logic       is_lower;
  logic       is_upper;
  logic       is_hex_alpha;

  assign b            = in_item.in_byte;
  assign is_digit     = (b >= 8'h30) && (b <= 8'h39);
  assign is_lower     = (b >= 8'h61) && (b <= 8'h7a);
  assign is_upper     = (b >= 8'h41) && (b <= 8'h5a);
  assign is_hex_alpha = ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.byte_val = b;
    q_data.is_plain = is_digit || is_lower || is_upper;
    q_data.is_pct   = (b == urlpd_pkg::CHAR_PCT);
    q_data.is_u     = (b == urlpd_pkg::CHAR_U);
    q_data.hex_ok   = is_digit || is_hex_alpha;
    // letters a-f / A-F have low nibble 1..6
    q_data.hex_val  = is_digit ? b[3:0] : (b[3:0] + 4'd9);
    q_data.last     = in_item.end_of_string;
  end

endmodule

### sv/urlpd_queue.sv
module urlpd_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  urlpd_pkg::cls_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output urlpd_pkg::cls_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  urlpd_pkg::cls_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/urlpd_back.sv
module urlpd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  urlpd_pkg::cls_t      q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output urlpd_pkg::out_item_t out_item
);

  urlpd_pkg::phase_t    phase_r, phase_nxt, phase_step;
  logic [1:0]           digit_r, digit_nxt;
  logic [11:0]          held_r, held_nxt;
  logic                 out_valid_r;
  urlpd_pkg::out_item_t out_item_r;
  logic                 emit;
  urlpd_pkg::out_item_t res;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // next state
  always_comb begin
    phase_step = phase_r;
    digit_nxt  = digit_r;
    held_nxt   = held_r;
    case (phase_r)
      urlpd_pkg::PH_IDLE: begin
        if (q_data.is_plain) begin
          phase_step = urlpd_pkg::PH_IDLE;
        end else if (q_data.is_pct) begin
          phase_step = urlpd_pkg::PH_PERCENT;
        end else begin
          phase_step = urlpd_pkg::PH_HALTED;
        end
      end
      urlpd_pkg::PH_PERCENT: begin
        if (q_data.is_u) begin
          phase_step = urlpd_pkg::PH_UDIGITS;
          digit_nxt  = '0;
          held_nxt   = '0;
        end else if (q_data.hex_ok) begin
          phase_step = urlpd_pkg::PH_SECOND;
          held_nxt   = {8'h00, q_data.hex_val};
        end else begin
          phase_step = urlpd_pkg::PH_HALTED;
        end
      end
      urlpd_pkg::PH_SECOND: begin
        if (q_data.hex_ok) begin
          phase_step = urlpd_pkg::PH_IDLE;
          held_nxt   = '0;
        end else begin
          phase_step = urlpd_pkg::PH_HALTED;
        end
      end
      urlpd_pkg::PH_UDIGITS: begin
        if (!q_data.hex_ok) begin
          phase_step = urlpd_pkg::PH_HALTED;
        end else if (digit_r != urlpd_pkg::LAST_U_DIGIT) begin
          held_nxt  = {held_r[7:0], q_data.hex_val};
          digit_nxt = digit_r + 1'b1;
        end else begin
          phase_step = urlpd_pkg::PH_IDLE;
          digit_nxt  = '0;
          held_nxt   = '0;
        end
      end
      default: begin
        phase_step = phase_r;
      end
    endcase
    phase_nxt = phase_step;
    if (q_data.last) begin
      phase_nxt = urlpd_pkg::PH_IDLE;
      digit_nxt = '0;
      held_nxt  = '0;
    end
  end

  // result
  always_comb begin
    res = '0;
    case (phase_r)
      urlpd_pkg::PH_IDLE: begin
        if (q_data.is_plain) begin
          res.first_byte = q_data.byte_val;
          res.byte_count = 2'd1;
        end
      end
      urlpd_pkg::PH_SECOND: begin
        if (q_data.hex_ok) begin
          res.first_byte = {held_r[3:0], q_data.hex_val};
          res.byte_count = 2'd1;
        end
      end
      urlpd_pkg::PH_UDIGITS: begin
        if (q_data.hex_ok && digit_r == urlpd_pkg::LAST_U_DIGIT) begin
          res.first_byte  = held_r[11:4];
          res.second_byte = {held_r[3:0], q_data.hex_val};
          res.byte_count  = 2'd2;
        end
      end
      default: begin
        res.byte_count = 2'd0;
      end
    endcase
    res.done_res      = q_data.last;
    res.stopped_early = q_data.last && (phase_step != urlpd_pkg::PH_IDLE);
    emit              = q_data.last || (res.byte_count != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= urlpd_pkg::PH_IDLE;
      digit_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r     <= phase_nxt;
        digit_r     <= digit_nxt;
        held_r      <= held_nxt;
        out_valid_r <= emit;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item_r <= res;
    end
  end

endmodule

### sv/url_percent_decoder_top.sv
// URL percent decoder, percent-u escapes included.
// Input channel: in_valid / in_stall / in_item, one encoded character per
// item, end_of_string set on the last character of a string.
// Output channel: out_valid / out_stall / out_item, at most one result per
// input item, carrying 0..2 decoded bytes; the last character always gives a
// result with done_res set and stopped_early flagging malformed input.
// A front stage classifies each character and writes it into a small queue
// (QUEUE_DEPTH items); the back stage pops it, runs the escape state machine
// and loads the output register.
// A result is registered: each item passes through the queue and is then
// decoded into the output register.
// Throughput: one item per cycle while no stalled result is pending, set by
// the single pop per cycle of the back state machine.
// Reset (rst_n low, synchronous) empties the queue and output register and
// returns the decoder to the start of a string.
// While out_stall is high the result holds; the queue keeps taking items
// until full, then in_stall rises.
module url_percent_decoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  urlpd_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output urlpd_pkg::out_item_t out_item
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  urlpd_pkg::cls_t q_wdata;
  urlpd_pkg::cls_t q_rdata;

  urlpd_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  urlpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  urlpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
